### src/scfl_pkg.sv
package scfl_pkg;

  localparam int unsigned AddrW = 19;
  localparam int unsigned WordW = 16;
  localparam int unsigned ClsW = 5;
  localparam int unsigned MaxClasses = 16;
  localparam logic [AddrW-1:0] TagBytes = 19'd8;

  typedef enum logic [1:0] {
    StatusOk = 2'd0,
    StatusTooLarge = 2'd1,
    StatusNoPages = 2'd2
  } status_e;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  typedef struct packed {
    logic op;
    logic [15:0] request_bytes;
    logic [AddrW-1:0] chunk_address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] granted_address;
    logic [1:0] status;
  } rsp_t;

  function automatic logic [12:0] class_size(input logic [3:0] idx);
    logic [12:0] s;
    case (idx)
      4'd0: s = 13'd16;
      4'd1: s = 13'd24;
      4'd2: s = 13'd32;
      4'd3: s = 13'd48;
      4'd4: s = 13'd64;
      4'd5: s = 13'd96;
      4'd6: s = 13'd128;
      4'd7: s = 13'd192;
      4'd8: s = 13'd256;
      4'd9: s = 13'd384;
      4'd10: s = 13'd512;
      4'd11: s = 13'd768;
      4'd12: s = 13'd1024;
      4'd13: s = 13'd1536;
      4'd14: s = 13'd2048;
      default: s = 13'd3072;
    endcase
    return s;
  endfunction

endpackage

### src/scfl_fit.sv
module scfl_fit #(
  parameter int unsigned CLASS_COUNT = 16
) (
  input  logic [16:0] bytes_i,
  output logic [4:0]  class_o
);
  import scfl_pkg::*;

  // smallest class with size >= bytes, CLASS_COUNT when none fits
  always_comb begin
    class_o = 5'(CLASS_COUNT);
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (bytes_i <= {4'd0, class_size(4'(i))}) begin
        class_o = 5'(i);
      end
    end
  end
endmodule

### src/size_class_free_list_allocator.sv
// size class free list allocator
//
// command channel: present a word on req_i with start_i high while busy_o
// is low; it is taken at that edge and busy_o rises. one result word comes
// back on rsp_o with done_o high for a single cycle; the receiver cannot
// stall it, so it must sample done_o every cycle.
//
// sequence after the accepting edge: a too-large request or a free of a zero
// chunk goes straight from decode to the result. a free reads the tag from
// the heap memory, then writes the link. an alloc selects a list: a pop of
// the own list goes to the result, a split from a larger list goes on to
// the remainder rule, and a fresh page carve pushes the same-class chunks
// and then the remainder chunks. busy_o stays high through the result
// cycle, so the next word is taken in the cycle after the result.
//
// reset clears the class heads (flip-flops) and the page counter; the heap
// memory is not cleared, and a free of a never-granted address is
// undefined.
module size_class_free_list_allocator #(
  parameter int unsigned PAGE_COUNT = 64,
  parameter int unsigned PAGE_BYTES = 8192,
  parameter int unsigned CLASS_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  scfl_pkg::req_t    req_i,
  output logic              busy_o,
  output logic              done_o,
  output scfl_pkg::rsp_t    rsp_o
);
  import scfl_pkg::*;

  localparam int unsigned PageW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned ClsIdxW = 4;
  localparam int unsigned CarveBytes = PAGE_BYTES - 8;

  // same-class chunks pushed after the granted one on a fresh page
  localparam logic [12:0] EntriesTab [MaxClasses] = '{
    13'(CarveBytes / 16 - 1),   13'(CarveBytes / 24 - 1),
    13'(CarveBytes / 32 - 1),   13'(CarveBytes / 48 - 1),
    13'(CarveBytes / 64 - 1),   13'(CarveBytes / 96 - 1),
    13'(CarveBytes / 128 - 1),  13'(CarveBytes / 192 - 1),
    13'(CarveBytes / 256 - 1),  13'(CarveBytes / 384 - 1),
    13'(CarveBytes / 512 - 1),  13'(CarveBytes / 768 - 1),
    13'(CarveBytes / 1024 - 1), 13'(CarveBytes / 1536 - 1),
    13'(CarveBytes / 2048 - 1), 13'(CarveBytes / 3072 - 1)
  };

  // page tail left for the remainder rule
  localparam logic [13:0] RestTab [MaxClasses] = '{
    14'(CarveBytes % 16),   14'(CarveBytes % 24),
    14'(CarveBytes % 32),   14'(CarveBytes % 48),
    14'(CarveBytes % 64),   14'(CarveBytes % 96),
    14'(CarveBytes % 128),  14'(CarveBytes % 192),
    14'(CarveBytes % 256),  14'(CarveBytes % 384),
    14'(CarveBytes % 512),  14'(CarveBytes % 768),
    14'(CarveBytes % 1024), 14'(CarveBytes % 1536),
    14'(CarveBytes % 2048), 14'(CarveBytes % 3072)
  };

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StDecode = 8'b0000_0010,  // op and class decode, tag read for a free
    StSelect = 8'b0000_0100,  // pick own list, larger list or fresh page
    StPop    = 8'b0000_1000,  // link valid, write tag of granted chunk
    StCarve  = 8'b0001_0000,  // push chunks of the same class
    StRest   = 8'b0010_0000,  // remainder rule
    StFree   = 8'b0100_0000,  // tag valid, push freed chunk
    StDone   = 8'b1000_0000
  } state_e;

  state_e state_q;

  logic [AddrW-1:0] heads_q [MaxClasses];
  logic [PageW-1:0] page_q;
  logic [AddrW-1:0] heap_mem [2**WordW];
  logic [AddrW-1:0] rd_data_q;

  req_t req_q;
  logic [ClsW-1:0] cls_q;        // requested class
  logic [ClsIdxW-1:0] src_q;     // class popped from
  logic [AddrW-1:0] loc_q;       // carve cursor
  logic [13:0] rem_q;            // carve bytes left
  logic [12:0] cnt_q;            // same-class chunks left
  logic [1:0] status_q;
  logic [AddrW-1:0] grant_q;

  // heap port
  logic we;
  logic [WordW-1:0] waddr, raddr;
  logic [AddrW-1:0] wdata;
  logic re;

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= heap_mem[raddr];
    end
  end

  // class fit for the request and for the carve remainder
  logic [4:0] fit_req, fit_rem;
  scfl_fit #(.CLASS_COUNT(CLASS_COUNT)) u_fit_req (
    .bytes_i({1'b0, req_q.request_bytes} + 17'd8),
    .class_o(fit_req)
  );
  scfl_fit #(.CLASS_COUNT(CLASS_COUNT)) u_fit_rem (
    .bytes_i({3'd0, rem_q}),
    .class_o(fit_rem)
  );

  logic [ClsIdxW-1:0] cls_idx;
  assign cls_idx = cls_q[ClsIdxW-1:0];

  // nearest larger nonempty class
  logic found;
  logic [ClsIdxW-1:0] larger;
  always_comb begin
    found = 1'b0;
    larger = '0;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (5'(i) > cls_q && heads_q[i] != '0) begin
        found = 1'b1;
        larger = ClsIdxW'(i);
      end
    end
  end

  logic [AddrW-1:0] free_chunk;
  assign free_chunk = (req_q.chunk_address - TagBytes) & ~19'd7;

  logic [AddrW-1:0] page_base;
  assign page_base = AddrW'(32'(page_q) * PAGE_BYTES) + TagBytes;

  logic pages_out;
  assign pages_out = (32'(page_q) >= PAGE_COUNT);

  logic [12:0] sz_c;
  assign sz_c = class_size(cls_idx);

  logic [AddrW-1:0] pop_chunk;
  assign pop_chunk = heads_q[src_q];

  // remainder rule: largest class strictly below the fit of the tail
  logic rest_ok;
  logic [3:0] rest_cls;
  logic [12:0] rest_sz;
  assign rest_ok = (fit_rem < 5'(CLASS_COUNT)) && (fit_rem != 5'd0);
  assign rest_cls = 4'(fit_rem - 5'd1);
  assign rest_sz = class_size(rest_cls);

  logic tag_ok;
  assign tag_ok = (rd_data_q < AddrW'(CLASS_COUNT));

  // heap accesses, at most one per cycle
  always_comb begin
    we = 1'b0;
    re = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    unique case (state_q)
      StDecode: begin
        if (req_q.op == OpFree && free_chunk != '0) begin
          re = 1'b1;
          raddr = free_chunk[WordW+2:3];
        end
      end
      StSelect: begin
        if (heads_q[cls_idx] != '0) begin
          re = 1'b1;
          raddr = heads_q[cls_idx][WordW+2:3];
        end else if (found) begin
          re = 1'b1;
          raddr = heads_q[larger][WordW+2:3];
        end else if (!pages_out) begin
          we = 1'b1;
          waddr = page_base[WordW+2:3];
          wdata = AddrW'(cls_q);
        end
      end
      StPop: begin
        we = 1'b1;
        waddr = pop_chunk[WordW+2:3];
        wdata = AddrW'(cls_q);
      end
      StCarve: begin
        if (cnt_q != '0) begin
          we = 1'b1;
          waddr = loc_q[WordW+2:3];
          wdata = heads_q[cls_idx];
        end
      end
      StRest: begin
        if (rest_ok) begin
          we = 1'b1;
          waddr = loc_q[WordW+2:3];
          wdata = heads_q[rest_cls];
        end
      end
      StFree: begin
        if (tag_ok) begin
          we = 1'b1;
          waddr = free_chunk[WordW+2:3];
          wdata = heads_q[rd_data_q[ClsIdxW-1:0]];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      page_q <= '0;
      for (int i = 0; i < MaxClasses; i++) begin
        heads_q[i] <= '0;
      end
      req_q <= '0;
      cls_q <= '0;
      src_q <= '0;
      loc_q <= '0;
      rem_q <= '0;
      cnt_q <= '0;
      status_q <= StatusOk;
      grant_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            req_q <= req_i;
            status_q <= StatusOk;
            grant_q <= '0;
            state_q <= StDecode;
          end
        end
        StDecode: begin
          if (req_q.op == OpFree) begin
            // a chunk starting at zero cannot exist, drop it
            state_q <= (free_chunk == '0) ? StDone : StFree;
          end else if (fit_req >= 5'(CLASS_COUNT)) begin
            status_q <= StatusTooLarge;
            state_q <= StDone;
          end else begin
            cls_q <= fit_req;
            state_q <= StSelect;
          end
        end
        StSelect: begin
          if (heads_q[cls_idx] != '0) begin
            src_q <= cls_idx;
            state_q <= StPop;
          end else if (found) begin
            src_q <= larger;
            state_q <= StPop;
          end else if (pages_out) begin
            status_q <= StatusNoPages;
            state_q <= StDone;
          end else begin
            // fresh page: first chunk granted, tag written this cycle
            page_q <= page_q + PageW'(1);
            grant_q <= page_base + TagBytes;
            loc_q <= page_base + AddrW'(sz_c);
            cnt_q <= EntriesTab[cls_idx];
            rem_q <= RestTab[cls_idx];
            state_q <= StCarve;
          end
        end
        StPop: begin
          heads_q[src_q] <= rd_data_q;
          grant_q <= pop_chunk + TagBytes;
          loc_q <= pop_chunk + AddrW'(sz_c);
          rem_q <= 14'(class_size(src_q) - sz_c);
          state_q <= (src_q == cls_idx) ? StDone : StRest;
        end
        StCarve: begin
          if (cnt_q != '0) begin
            heads_q[cls_idx] <= loc_q;
            loc_q <= loc_q + AddrW'(sz_c);
            cnt_q <= cnt_q - 13'd1;
          end else begin
            state_q <= StRest;
          end
        end
        StRest: begin
          if (rest_ok) begin
            heads_q[rest_cls] <= loc_q;
            loc_q <= loc_q + AddrW'(rest_sz);
            rem_q <= rem_q - {1'b0, rest_sz};
          end else begin
            state_q <= StDone;
          end
        end
        StFree: begin
          // a tag outside the class range means a bad free, ignore it
          if (tag_ok) begin
            heads_q[rd_data_q[ClsIdxW-1:0]] <= free_chunk;
          end
          state_q <= StDone;
        end
        StDone: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);
  assign rsp_o.granted_address = grant_q;
  assign rsp_o.status = status_q;

endmodule
